### sv/fpra_pkg.sv
// Shared types and constants for the first-fit page run allocator.
`timescale 1ns / 1ps

package fpra_pkg;

    // Fixed field widths
    localparam int CFG_W  = 13;
    localparam int LEN_W  = 8;
    localparam int PAGE_W = 12;
    localparam int MODE_W = 2;
    localparam int CIDX_W = 1;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_PAGE_COUNT = 1'b0;
    localparam logic [CIDX_W-1:0] REG_RESERVED   = 1'b1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] PAGE_COUNT_RST = 13'd4096;
    localparam logic [CFG_W-1:0] RESERVED_RST   = 13'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CMD,
        ST_SCAN,
        ST_QRD
    } fpra_state_t;

    // Table port control from sequencer
    typedef struct packed {
        logic rd;
        logic wr;
    } fpra_tbl_ctl_t;

endpackage

### sv/first_fit_page_run_allocator_unit.sv
// Top level of the first-fit page run allocator.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   request  | start / busy         | mode, run_length, page_index
//   result   | done (1-cycle pulse) | ok, start_page, length_out
//   config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// After reset the table is cleared one entry a cycle, with busy high. Allocate walks the
// table from reserved towards limit, where limit is page_count clamped to MAX_PAGES;
// the single table read port and the step adder set the walk rate, one entry per cycle.
// The result pulse is not held; busy drops in the cycle the pulse appears.
`timescale 1ns / 1ps

module first_fit_page_run_allocator_unit
    import fpra_pkg::*;
#(
    parameter int MAX_PAGES = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] mode,
    input  logic [LEN_W-1:0]  run_length,
    input  logic [PAGE_W-1:0] page_index,
    output logic              done,
    output logic              ok,
    output logic [PAGE_W-1:0] start_page,
    output logic [LEN_W-1:0]  length_out,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_PAGES);
    localparam int IW = ($clog2(MAX_PAGES + 256) > 14) ? $clog2(MAX_PAGES + 256) : 14;

    logic [CFG_W-1:0] page_count_reg, page_count_next;
    logic [CFG_W-1:0] reserved_reg, reserved_next;
    logic [IW-1:0]    pc_wide;
    logic [IW-1:0]    limit;
    logic [IW-1:0]    reserved;

    fpra_tbl_ctl_t    tbl_ctl;
    logic [AW-1:0]    tbl_addr;
    logic [LEN_W-1:0] tbl_wdata;
    logic [LEN_W-1:0] tbl_rdata;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        page_count_next = page_count_reg;
        reserved_next   = reserved_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PAGE_COUNT: page_count_next = cfg_data;
                REG_RESERVED:   reserved_next   = cfg_data;
                default:        page_count_next = page_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_count_reg <= PAGE_COUNT_RST;
            reserved_reg   <= RESERVED_RST;
        end
        else
        begin
            page_count_reg <= page_count_next;
            reserved_reg   <= reserved_next;
        end
    end

    // Effective page limit, clamped to the table depth
    always_comb
    begin
        pc_wide  = IW'(page_count_reg);
        limit    = (pc_wide > IW'(MAX_PAGES)) ? IW'(MAX_PAGES) : pc_wide;
        reserved = IW'(reserved_reg);
    end

    fpra_seq #(
        .MAX_PAGES (MAX_PAGES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode),
        .run_length (run_length),
        .page_index (page_index),
        .limit      (limit),
        .reserved   (reserved),
        .busy       (busy),
        .done       (done),
        .ok         (ok),
        .start_page (start_page),
        .length_out (length_out),
        .tbl_ctl    (tbl_ctl),
        .tbl_addr   (tbl_addr),
        .tbl_wdata  (tbl_wdata),
        .tbl_rdata  (tbl_rdata)
    );

    fpra_table #(
        .MAX_PAGES (MAX_PAGES)
    ) u_table (
        .clk   (clk),
        .ctl   (tbl_ctl),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

endmodule

### sv/fpra_table.sv
// Run length table: one byte per page, single port, registered read.
`timescale 1ns / 1ps

module fpra_table
    import fpra_pkg::*;
#(
    parameter int MAX_PAGES = 4096
)
(
    input  logic                         clk,
    input  fpra_tbl_ctl_t                ctl,
    input  logic [$clog2(MAX_PAGES)-1:0] addr,
    input  logic [LEN_W-1:0]             wdata,
    output logic [LEN_W-1:0]             rdata
);

    logic [LEN_W-1:0] mem [MAX_PAGES];
    logic [LEN_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/fpra_seq.sv
// Sequencer: clearing pass, command decode and the first-fit table walk.
`timescale 1ns / 1ps

module fpra_seq
    import fpra_pkg::*;
#(
    parameter int MAX_PAGES = 4096
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [MODE_W-1:0]            mode,
    input  logic [LEN_W-1:0]             run_length,
    input  logic [PAGE_W-1:0]            page_index,
    input  logic [((($clog2(MAX_PAGES + 256)) > 14) ?
                   $clog2(MAX_PAGES + 256) : 14)-1:0] limit,
    input  logic [((($clog2(MAX_PAGES + 256)) > 14) ?
                   $clog2(MAX_PAGES + 256) : 14)-1:0] reserved,
    output logic                         busy,
    output logic                         done,
    output logic                         ok,
    output logic [PAGE_W-1:0]            start_page,
    output logic [LEN_W-1:0]             length_out,
    output fpra_tbl_ctl_t                tbl_ctl,
    output logic [$clog2(MAX_PAGES)-1:0] tbl_addr,
    output logic [LEN_W-1:0]             tbl_wdata,
    input  logic [LEN_W-1:0]             tbl_rdata
);

    localparam int AW = $clog2(MAX_PAGES);
    localparam int IW = ($clog2(MAX_PAGES + 256) > 14) ? $clog2(MAX_PAGES + 256) : 14;

    fpra_state_t state_reg, state_next;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     base_reg, base_next;
    logic [LEN_W-1:0]  found_reg, found_next;
    logic [AW-1:0]     clr_reg, clr_next;

    logic              done_reg, done_next;
    logic              ok_reg, ok_next;
    logic [PAGE_W-1:0] spage_reg, spage_next;
    logic [LEN_W-1:0]  lout_reg, lout_next;

    // Shared step adder and compares
    logic [IW-1:0]    step;
    logic [IW-1:0]    sum;
    logic [LEN_W-1:0] found_inc;
    logic [IW-1:0]    run_base;
    logic [IW-1:0]    page_wide;
    logic             entry_free;
    logic             fit;
    logic             past_end;
    logic             page_ok;
    logic             alloc_go;
    logic             clr_last;

    always_comb
    begin
        entry_free = (tbl_rdata == '0);
        step       = entry_free ? IW'(1) : IW'(tbl_rdata);
        sum        = idx_reg + step;
        found_inc  = found_reg + LEN_W'(1);
        run_base   = (found_reg == '0) ? idx_reg : base_reg;
        fit        = entry_free && (found_inc >= len_reg);
        past_end   = (sum >= limit);
        page_wide  = IW'(page_reg);
        page_ok    = (page_wide < limit);
        alloc_go   = (len_reg != '0) && (reserved < limit);
        clr_last   = (clr_reg == AW'(MAX_PAGES - 1));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                unique case (mode_reg)
                    MODE_ALLOC: state_next = alloc_go ? ST_SCAN : ST_IDLE;
                    MODE_QUERY: state_next = page_ok ? ST_QRD : ST_IDLE;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_SCAN:
            begin
                if (fit || past_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, table port and results
    always_comb
    begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        page_next  = page_reg;
        idx_next   = idx_reg;
        base_next  = base_reg;
        found_next = found_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        spage_next = spage_reg;
        lout_next  = lout_reg;
        tbl_ctl    = '0;
        tbl_addr   = '0;
        tbl_wdata  = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                tbl_ctl.wr = 1'b1;
                tbl_addr   = clr_reg;
                clr_next   = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode;
                    len_next  = run_length;
                    page_next = page_index;
                end
            end
            ST_CMD:
            begin
                // default: a failed request
                done_next  = 1'b1;
                ok_next    = 1'b0;
                spage_next = '0;
                lout_next  = '0;
                unique case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (alloc_go)
                        begin
                            done_next  = 1'b0;
                            tbl_ctl.rd = 1'b1;
                            tbl_addr   = reserved[AW-1:0];
                            idx_next   = reserved;
                            found_next = '0;
                        end
                    end
                    MODE_FREE:
                    begin
                        if (page_ok)
                        begin
                            tbl_ctl.wr = 1'b1;
                            tbl_addr   = page_wide[AW-1:0];
                            ok_next    = 1'b1;
                        end
                    end
                    MODE_QUERY:
                    begin
                        if (page_ok)
                        begin
                            done_next  = 1'b0;
                            tbl_ctl.rd = 1'b1;
                            tbl_addr   = page_wide[AW-1:0];
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ST_SCAN:
            begin
                // tbl_rdata holds the entry at idx_reg
                if (entry_free)
                begin
                    found_next = found_inc;
                    base_next  = run_base;
                end
                else
                begin
                    found_next = '0;
                end
                if (fit)
                begin
                    tbl_ctl.wr = 1'b1;
                    tbl_addr   = run_base[AW-1:0];
                    tbl_wdata  = len_reg;
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    spage_next = run_base[PAGE_W-1:0];
                    lout_next  = len_reg;
                end
                else if (past_end)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b0;
                    spage_next = '0;
                    lout_next  = '0;
                end
                else
                begin
                    tbl_ctl.rd = 1'b1;
                    tbl_addr   = sum[AW-1:0];
                    idx_next   = sum;
                end
            end
            ST_QRD:
            begin
                done_next  = 1'b1;
                ok_next    = 1'b1;
                spage_next = '0;
                lout_next  = tbl_rdata;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        len_reg   <= len_next;
        page_reg  <= page_next;
        idx_reg   <= idx_next;
        base_reg  <= base_next;
        found_reg <= found_next;
        ok_reg    <= ok_next;
        spage_reg <= spage_next;
        lout_reg  <= lout_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign start_page = spage_reg;
    assign length_out = lout_reg;

endmodule
